@@ sv/itp_pkg.sv @@
package itp_pkg;

    // Input token kinds (s_tuser)
    localparam logic [2:0] TOK_NUMBER   = 3'd0;
    localparam logic [2:0] TOK_VARIABLE = 3'd1;
    localparam logic [2:0] TOK_LPAREN   = 3'd2;
    localparam logic [2:0] TOK_RPAREN   = 3'd3;
    localparam logic [2:0] TOK_OPERATOR = 3'd4;
    localparam logic [2:0] TOK_END      = 3'd5;

    // Operator codes; the paren mark shares the stack entry encoding
    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_SUB     = 3'd1;
    localparam logic [2:0] OP_MUL     = 3'd2;
    localparam logic [2:0] OP_DIV     = 3'd3;
    localparam logic [2:0] OP_MOD     = 3'd4;
    localparam logic [2:0] PAREN_MARK = 3'd5;

    // Result kinds (m_tuser)
    localparam logic [2:0] KIND_NUMBER   = 3'd0;
    localparam logic [2:0] KIND_VARIABLE = 3'd1;
    localparam logic [2:0] KIND_OPERATOR = 3'd2;
    localparam logic [2:0] KIND_DONE     = 3'd3;
    localparam logic [2:0] KIND_ERROR    = 3'd4;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_INVALID   = 2'd1;
    localparam logic [1:0] ERR_UNMATCHED = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

    localparam int DEF_STACK_DEPTH = 32;
    localparam int QUEUE_DEPTH     = 2;
    localparam int IN_DATA_W       = 48;
    localparam int OUT_DATA_W      = 48;

    typedef enum logic [2:0] {
        CMD_NUMBER,
        CMD_VARIABLE,
        CMD_LPAREN,
        CMD_RPAREN,
        CMD_OPER,
        CMD_END,
        CMD_BAD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] data;
    } cmd_t;

    // Precedence: paren mark ranks below every operator
    function automatic logic [1:0] op_rank(input logic [2:0] code);
        logic [1:0] r;
        begin
            r = 2'd0;
            if (code == OP_MUL || code == OP_DIV || code == OP_MOD)
            begin
                r = 2'd2;
            end
            else if (code == OP_ADD || code == OP_SUB)
            begin
                r = 2'd1;
            end
            return r;
        end
    endfunction

endpackage

@@ sv/infix_to_postfix_converter_core.sv @@
// Channel  Dir  Handshake          Content
// s_*      in   s_tvalid/s_tready  s_tuser: operation; s_tdata: op_code, number_value, var_code
// m_*      out  m_tvalid/m_tready  m_tuser: item_kind; m_tdata: out_op, out_number, out_var,
//                                  error_code; m_tlast: last word of a token
//
// The front end classifies one word per cycle into a 2-entry command queue while
// the queue is not full. The back end works one command step at a time: a token
// that pops n operators (right paren, operator, end) takes n+1 steps, one stack pop
// per step with the entry under the top prefetched from the stack RAM; other tokens
// take one step. Reset clears the queue, stack count, discard flag and output valid;
// the stack RAM is not cleared. A stalled output word holds the back end while the
// queue keeps taking words until it is full.
module infix_to_postfix_converter_core
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2:0]            s_tuser,   // operation
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [2:0] op_code, [34:3] number_value,
                                             // [42:35] var_code
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2:0]            m_tuser,   // item_kind
    output logic [OUT_DATA_W-1:0] m_tdata,   // [2:0] out_op, [34:3] out_number,
                                             // [42:35] out_var, [44:43] error_code
    output logic                  m_tlast
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    itp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .cmd_valid(cmd_valid),
        .cmd      (cmd),
        .cmd_pop  (cmd_pop)
    );

    itp_back #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd      (cmd),
        .cmd_pop  (cmd_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ sv/itp_ram.sv @@
module itp_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/itp_front.sv @@
module itp_front
    import itp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [2:0]           s_tuser,   // operation
    input  logic [IN_DATA_W-1:0] s_tdata,   // op_code, number_value, var_code
    output logic                 cmd_valid,
    output cmd_t                 cmd,
    input  logic                 cmd_pop
);

    localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t           q_reg [QUEUE_DEPTH];
    logic [QIW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QIW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] fill_reg, fill_next;
    cmd_t           in_cmd;
    logic           push;

    // Sort the token into a back-end command
    always_comb
    begin
        in_cmd.kind = CMD_BAD;
        in_cmd.data = '0;
        unique case (s_tuser)
            TOK_NUMBER:
            begin
                in_cmd.kind = CMD_NUMBER;
                in_cmd.data = s_tdata[34:3];
            end
            TOK_VARIABLE:
            begin
                in_cmd.kind = CMD_VARIABLE;
                in_cmd.data = {24'd0, s_tdata[42:35]};
            end
            TOK_LPAREN:   in_cmd.kind = CMD_LPAREN;
            TOK_RPAREN:   in_cmd.kind = CMD_RPAREN;
            TOK_OPERATOR:
            begin
                if (s_tdata[2:0] <= OP_MOD)
                begin
                    in_cmd.kind = CMD_OPER;
                    in_cmd.data = {29'd0, s_tdata[2:0]};
                end
            end
            TOK_END:      in_cmd.kind = CMD_END;
            default:      in_cmd.kind = CMD_BAD;
        endcase
    end

    assign s_tready  = (fill_reg != QCW'(QUEUE_DEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QIW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QIW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

@@ sv/itp_back.sv @@
module itp_back
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd,
    output logic                  cmd_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2:0]            m_tuser,   // item_kind
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_op, out_number, out_var, error_code
    output logic                  m_tlast
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  op;
        logic [31:0] number;
        logic [7:0]  var_code;
        logic [1:0]  err;
        logic        last;
    } out_item_t;

    logic [CW-1:0] count_reg, count_next;
    logic [2:0]    top_reg, top_next;
    logic [2:0]    below_reg, below_next;
    logic          fresh_reg, fresh_next;
    logic          disc_reg, disc_next;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_item_reg;

    logic [2:0]    below;
    logic [2:0]    rd_data;
    logic [AW-1:0] rd_addr;
    logic          ram_we;
    logic [2:0]    push_code;
    logic          do_push, do_pop, do_clear;
    logic          step, full, has_two;
    logic          emit;
    out_item_t     emit_item;
    logic [1:0]    in_rank;

    function automatic out_item_t make_item(
        input logic [2:0]  kind,
        input logic [2:0]  op,
        input logic [31:0] number,
        input logic [7:0]  var_code,
        input logic [1:0]  err,
        input logic        last
    );
        out_item_t it;
        begin
            it.kind     = kind;
            it.op       = op;
            it.number   = number;
            it.var_code = var_code;
            it.err      = err;
            it.last     = last;
            return it;
        end
    endfunction

    // Entry under the top: straight from RAM right after a pop, else cached
    assign below   = fresh_reg ? rd_data : below_reg;
    assign step    = cmd_valid && (!out_valid_reg || m_tready);
    assign full    = (count_reg == CW'(STACK_DEPTH));
    assign has_two = (count_reg >= CW'(2));
    assign in_rank = op_rank(cmd.data[2:0]);

    always_comb
    begin
        cmd_pop   = 1'b0;
        emit      = 1'b0;
        emit_item = '0;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        do_clear  = 1'b0;
        push_code = PAREN_MARK;
        disc_next = disc_reg;
        if (step)
        begin
            if (disc_reg)
            begin
                // Drop tokens until the end of the expression
                cmd_pop = 1'b1;
                if (cmd.kind == CMD_END)
                begin
                    disc_next = 1'b0;
                end
            end
            else
            begin
                unique case (cmd.kind)
                    CMD_NUMBER:
                    begin
                        emit      = 1'b1;
                        emit_item = make_item(KIND_NUMBER, 3'd0, cmd.data, 8'd0,
                                              ERR_NONE, 1'b1);
                        cmd_pop   = 1'b1;
                    end
                    CMD_VARIABLE:
                    begin
                        emit      = 1'b1;
                        emit_item = make_item(KIND_VARIABLE, 3'd0, 32'd0, cmd.data[7:0],
                                              ERR_NONE, 1'b1);
                        cmd_pop   = 1'b1;
                    end
                    CMD_LPAREN:
                    begin
                        cmd_pop = 1'b1;
                        if (full)
                        begin
                            emit      = 1'b1;
                            emit_item = make_item(KIND_ERROR, 3'd0, 32'd0, 8'd0,
                                                  ERR_OVERFLOW, 1'b1);
                            do_clear  = 1'b1;
                            disc_next = 1'b1;
                        end
                        else
                        begin
                            do_push   = 1'b1;
                            push_code = PAREN_MARK;
                        end
                    end
                    CMD_RPAREN:
                    begin
                        if (count_reg == '0)
                        begin
                            cmd_pop   = 1'b1;
                            emit      = 1'b1;
                            emit_item = make_item(KIND_ERROR, 3'd0, 32'd0, 8'd0,
                                                  ERR_INVALID, 1'b1);
                            do_clear  = 1'b1;
                            disc_next = 1'b1;
                        end
                        else if (top_reg == PAREN_MARK)
                        begin
                            cmd_pop = 1'b1;
                            do_pop  = 1'b1;
                        end
                        else
                        begin
                            // Last operator when the matching paren sits right under it
                            emit      = 1'b1;
                            emit_item = make_item(KIND_OPERATOR, top_reg, 32'd0, 8'd0,
                                                  ERR_NONE, has_two && below == PAREN_MARK);
                            do_pop    = 1'b1;
                        end
                    end
                    CMD_OPER:
                    begin
                        if (count_reg != '0 && in_rank <= op_rank(top_reg))
                        begin
                            emit      = 1'b1;
                            emit_item = make_item(KIND_OPERATOR, top_reg, 32'd0, 8'd0,
                                                  ERR_NONE,
                                                  !(has_two && in_rank <= op_rank(below)));
                            do_pop    = 1'b1;
                        end
                        else if (full)
                        begin
                            cmd_pop   = 1'b1;
                            emit      = 1'b1;
                            emit_item = make_item(KIND_ERROR, 3'd0, 32'd0, 8'd0,
                                                  ERR_OVERFLOW, 1'b1);
                            do_clear  = 1'b1;
                            disc_next = 1'b1;
                        end
                        else
                        begin
                            cmd_pop   = 1'b1;
                            do_push   = 1'b1;
                            push_code = cmd.data[2:0];
                        end
                    end
                    CMD_END:
                    begin
                        if (count_reg == '0)
                        begin
                            cmd_pop   = 1'b1;
                            emit      = 1'b1;
                            emit_item = make_item(KIND_DONE, 3'd0, 32'd0, 8'd0,
                                                  ERR_NONE, 1'b1);
                        end
                        else if (top_reg == PAREN_MARK)
                        begin
                            cmd_pop   = 1'b1;
                            emit      = 1'b1;
                            emit_item = make_item(KIND_ERROR, 3'd0, 32'd0, 8'd0,
                                                  ERR_UNMATCHED, 1'b1);
                            do_clear  = 1'b1;
                        end
                        else
                        begin
                            emit      = 1'b1;
                            emit_item = make_item(KIND_OPERATOR, top_reg, 32'd0, 8'd0,
                                                  ERR_NONE, 1'b0);
                            do_pop    = 1'b1;
                        end
                    end
                    CMD_BAD:
                    begin
                        cmd_pop   = 1'b1;
                        emit      = 1'b1;
                        emit_item = make_item(KIND_ERROR, 3'd0, 32'd0, 8'd0,
                                              ERR_INVALID, 1'b1);
                        do_clear  = 1'b1;
                        disc_next = 1'b1;
                    end
                    default:
                    begin
                        cmd_pop = 1'b1;
                    end
                endcase
            end
        end
    end

    // Stack update: top and the entry under it live in registers, the rest in RAM
    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        below_next = below;
        fresh_next = 1'b0;
        ram_we     = 1'b0;
        if (do_clear)
        begin
            count_next = '0;
        end
        else if (do_push)
        begin
            ram_we     = 1'b1;
            count_next = count_reg + 1'b1;
            top_next   = push_code;
            below_next = top_reg;
        end
        else if (do_pop)
        begin
            count_next = count_reg - 1'b1;
            top_next   = below;
            fresh_next = 1'b1;
        end
    end

    // Prefetch the new under-top entry for the next cycle
    assign rd_addr = (count_next >= CW'(2)) ? AW'(count_next - CW'(2)) : '0;

    itp_ram #(
        .WIDTH(3),
        .DEPTH(STACK_DEPTH),
        .AW   (AW)
    ) u_stack_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[AW-1:0]),
        .wdata(push_code),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            fresh_reg     <= 1'b0;
            disc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            disc_reg      <= disc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg   <= top_next;
        below_reg <= below_next;
        if (emit)
        begin
            out_item_reg <= emit_item;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_item_reg.kind;
    assign m_tlast  = out_item_reg.last;
    assign m_tdata  = {3'd0, out_item_reg.err, out_item_reg.var_code,
                       out_item_reg.number, out_item_reg.op};

`ifndef NO_ASSERTIONS
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !full)
        else $error("push onto full stack");

    a_no_paren_emitted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.kind == KIND_OPERATOR) |-> out_item_reg.op != PAREN_MARK)
        else $error("paren mark emitted as operator");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.kind == KIND_ERROR) |-> out_item_reg.last)
        else $error("error item not marked last");

    a_clear_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_item.kind == KIND_ERROR) |=> count_reg == '0)
        else $error("stack not cleared after error");
`endif

endmodule
